[design/assert_macros.svh]
// Assertion macros used by the top-level design file.
// Clock, and reset where the macro takes one, are passed in by the user of each macro.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge, disabled while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising edge, also during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/egc_pkg.sv]
// Package for the embedding gist compressor: constants, item and state types.
// No dependencies; used by the front, back and top-level design files.
package egc_pkg;

    // Fixed geometry of the ports.
    localparam int VECTOR_LEN = 64;
    localparam int LANE_W     = 6;
    localparam int DATA_W     = 16;

    // Defaults for the top-level parameters.
    localparam int HISTORY_ROWS_DEF = 256;
    localparam int CONTEXT_ROWS_DEF = 16;

    // Register reset values.
    localparam logic [15:0] FORGET_RATE_RST    = 16'd3277;
    localparam logic [14:0] ZERO_THRESHOLD_RST = 15'd410;

    // Register indexes on the configuration port.
    localparam logic REG_FORGET_RATE    = 1'b0;
    localparam logic REG_ZERO_THRESHOLD = 1'b1;

    // Command codes.
    localparam logic CMD_PROCESS  = 1'b0;
    localparam logic CMD_RETRIEVE = 1'b1;

    // Salience of a lane that was never written (1.0 in Q3.12).
    localparam logic signed [15:0] SAL_ONE = 16'sd4096;

    // Classified item handed from the front to the back.
    typedef struct packed {
        logic                     cmd;
        logic [LANE_W-1:0]        lane;
        logic signed [DATA_W-1:0] avg;
    } t_item;

    // Back-end sequencer states.
    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_MIX,
        S_WGT,
        S_UPD,
        S_RSUM,
        S_DPREP,
        S_DIV,
        S_OUT
    } t_bstate;

endpackage

[design/embedding_gist_compressor_core.sv]
// Top level of the embedding gist compressor: configuration registers and
// the front and back ends. Depends on egc_pkg, egc_front, egc_back.

// After reset the block clears the history memory (HISTORY_ROWS*64 words,
// 16384 by default) and takes no beat in that time; registers may be
// written meanwhile. A process beat runs through the back-end steps in order:
// take the item, read the lane stores, mix, weight, write back, load the
// output register; the back end takes no new item until that result is
// loaded. A retrieve beat sums CONTEXT_ROWS history rows through the single
// history read port, which reads one row a cycle, and then runs a reciprocal
// divide that estimates the quotient and corrects it. A two-entry queue lets
// beats arrive while the back end is busy, and an output register holds each
// result until taken; while it is held the back end waits to load the next.
`include "assert_macros.svh"

module embedding_gist_compressor_core #(
    parameter int HISTORY_ROWS = egc_pkg::HISTORY_ROWS_DEF,
    parameter int CONTEXT_ROWS = egc_pkg::CONTEXT_ROWS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic                               i_command,
    input  logic [egc_pkg::LANE_W-1:0]         i_lane,
    input  logic signed [egc_pkg::DATA_W-1:0]  i_value_even,
    input  logic signed [egc_pkg::DATA_W-1:0]  i_value_odd,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic signed [egc_pkg::DATA_W-1:0]  o_result_value,
    output logic                               o_last_of_vector,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [2:0]                         paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    logic [15:0]    r_forget_rate;
    logic [14:0]    r_zero_threshold;
    logic           cfg_write;
    logic           clearing;
    logic           q_valid;
    logic           q_pop;
    egc_pkg::t_item q_item;

    // Configuration port.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_forget_rate    <= egc_pkg::FORGET_RATE_RST;
            r_zero_threshold <= egc_pkg::ZERO_THRESHOLD_RST;
        end else if (cfg_write) begin
            case (paddr[2])
                egc_pkg::REG_FORGET_RATE:    r_forget_rate    <= pwdata[15:0];
                egc_pkg::REG_ZERO_THRESHOLD: r_zero_threshold <= pwdata[14:0];
                default: ;
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        case (paddr[2])
            egc_pkg::REG_FORGET_RATE:    prdata = {16'd0, r_forget_rate};
            egc_pkg::REG_ZERO_THRESHOLD: prdata = {17'd0, r_zero_threshold};
            default:                     prdata = 32'd0;
        endcase
    end

    egc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_command    (i_command),
        .i_lane       (i_lane),
        .i_value_even (i_value_even),
        .i_value_odd  (i_value_odd),
        .i_clearing   (clearing),
        .o_q_valid    (q_valid),
        .o_q_item     (q_item),
        .i_q_pop      (q_pop)
    );

    egc_back #(
        .HISTORY_ROWS (HISTORY_ROWS),
        .CONTEXT_ROWS (CONTEXT_ROWS)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_valid        (q_valid),
        .i_q_item         (q_item),
        .o_q_pop          (q_pop),
        .i_forget_rate    (r_forget_rate),
        .i_zero_threshold (r_zero_threshold),
        .o_clearing       (clearing),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_result_value   (o_result_value),
        .o_last_of_vector (o_last_of_vector)
    );

    // Checks on the block's own control.
    `ASSERT_CLK(a_clear_blocks_input, i_clk, i_rst_n, clearing |-> !o_in_ready, "beat taken during clear")
    `ASSERT_CLK(a_clear_no_output, i_clk, i_rst_n, clearing |-> !o_out_valid, "result during clear")
    `ASSERT_CLK(a_forget_written, i_clk, i_rst_n, (cfg_write && paddr[2] == egc_pkg::REG_FORGET_RATE) |=> (r_forget_rate == $past(pwdata[15:0])), "forget rate not written")
    `ASSERT_CLK(a_pop_needs_item, i_clk, i_rst_n, q_pop |-> q_valid, "pop from empty queue")

endmodule

[design/egc_front.sv]
// Front end: accepts input beats, averages the embedding pair and queues
// the classified item in a two-entry queue. Depends on egc_pkg.
module egc_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic                               i_command,
    input  logic [egc_pkg::LANE_W-1:0]         i_lane,
    input  logic signed [egc_pkg::DATA_W-1:0]  i_value_even,
    input  logic signed [egc_pkg::DATA_W-1:0]  i_value_odd,
    input  logic                               i_clearing,
    output logic                               o_q_valid,
    output egc_pkg::t_item                     o_q_item,
    input  logic                               i_q_pop
);

    egc_pkg::t_item r_q [2];
    logic           r_wr_ptr;
    logic           r_rd_ptr;
    logic [1:0]     r_count;
    logic           push;
    logic signed [egc_pkg::DATA_W:0] pair_sum;
    egc_pkg::t_item new_item;

    // Floor average of the pair; lane is already within the vector.
    always_comb begin
        pair_sum      = {i_value_even[egc_pkg::DATA_W-1], i_value_even}
                      + {i_value_odd[egc_pkg::DATA_W-1], i_value_odd};
        new_item.cmd  = i_command;
        new_item.lane = i_lane;
        new_item.avg  = pair_sum[egc_pkg::DATA_W:1];
    end

    // No beat is taken while the history is being cleared.
    assign o_in_ready = (r_count != 2'd2) && !i_clearing;
    assign push       = i_in_valid && o_in_ready;
    assign o_q_valid  = (r_count != 2'd0);
    assign o_q_item   = r_q[r_rd_ptr];

    // Queue pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) r_wr_ptr <= !r_wr_ptr;
            if (i_q_pop) r_rd_ptr <= !r_rd_ptr;
            if (push && !i_q_pop) r_count <= r_count + 2'd1;
            else if (!push && i_q_pop) r_count <= r_count - 2'd1;
        end
    end

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wr_ptr] <= new_item;
    end

endmodule

[design/egc_back.sv]
// Back end: sequencer that runs process and retrieve items against the lane
// stores and the history memory, with the output register. Depends on egc_pkg.
module egc_back #(
    parameter int HISTORY_ROWS = egc_pkg::HISTORY_ROWS_DEF,
    parameter int CONTEXT_ROWS = egc_pkg::CONTEXT_ROWS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_q_valid,
    input  egc_pkg::t_item                     i_q_item,
    output logic                               o_q_pop,
    input  logic [15:0]                        i_forget_rate,
    input  logic [14:0]                        i_zero_threshold,
    output logic                               o_clearing,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic signed [egc_pkg::DATA_W-1:0]  o_result_value,
    output logic                               o_last_of_vector
);

    localparam int HR_W    = $clog2(HISTORY_ROWS);
    localparam int LW      = egc_pkg::LANE_W;
    localparam int AW      = HR_W + LW;
    localparam int DEPTH   = HISTORY_ROWS * egc_pkg::VECTOR_LEN;
    localparam int OFF     = CONTEXT_ROWS % HISTORY_ROWS;
    localparam int CNT_W   = $clog2(CONTEXT_ROWS + 1);
    localparam int SUM_W   = egc_pkg::DATA_W + $clog2(CONTEXT_ROWS) + 1;
    localparam int N_W     = SUM_W + 2;
    localparam int DIVISOR = 2 * CONTEXT_ROWS;

    // Reciprocal of the divisor scaled by 2^N_W; the estimate it gives is at
    // most one below the true quotient.
    localparam longint RECIP = (longint'(1) << N_W) / DIVISOR;
    localparam logic [N_W-1:0] K_RECIP = N_W'(RECIP);
    localparam logic [N_W-1:0] K_DIV   = N_W'(DIVISOR);

    localparam logic signed [35:0] K_MIX_NEW = 36'sd45875;
    localparam logic signed [35:0] K_MIX_OLD = 36'sd19661;
    localparam logic signed [35:0] K_SAL_OLD = 36'sd58982;
    localparam logic signed [35:0] K_SAL_NEW = 36'sd6554;

    // Sign-extend a data word to the arithmetic width.
    function automatic logic signed [35:0] sx16(input logic signed [15:0] v);
        sx16 = {{20{v[15]}}, v};
    endfunction

    // Saturate to the signed 16-bit range.
    function automatic logic signed [15:0] sat16(input logic signed [35:0] v);
        if (v > 36'sd32767) sat16 = 16'sh7fff;
        else if (v < -36'sd32768) sat16 = 16'sh8000;
        else sat16 = v[15:0];
    endfunction

    egc_pkg::t_bstate r_state, n_state;
    egc_pkg::t_item   r_item;

    logic [AW-1:0]          r_clr_addr;
    logic [HR_W-1:0]        r_head;
    logic [egc_pkg::VECTOR_LEN-1:0] r_vld;
    logic signed [15:0]     rec_mem [egc_pkg::VECTOR_LEN];
    logic signed [15:0]     sal_mem [egc_pkg::VECTOR_LEN];
    logic signed [15:0]     hist_mem [DEPTH];
    logic signed [15:0]     r_rec_q, r_sal_q, r_hist_q;
    logic                   r_lane_vld;

    logic signed [15:0]     r_mixed, r_sal_eff, r_w, r_res;
    logic [16:0]            r_mag;
    logic [HR_W-1:0]        r_row;
    logic [CNT_W-1:0]       r_cnt;
    logic                   r_acc_en;
    logic signed [SUM_W-1:0] r_sum;
    logic                   r_neg;
    logic [N_W-1:0]         r_a;
    logic [N_W-1:0]         r_q0;
    logic                   r_dstep;
    logic                   r_out_valid;
    logic signed [15:0]     r_out_value;
    logic                   r_out_last;

    // Control strobes.
    logic            hist_we;
    logic [AW-1:0]   hist_waddr;
    logic signed [15:0] hist_wdata;
    logic            lane_we;
    logic            out_load;

    // Datapath signals.
    logic signed [15:0] rec_eff, sal_eff, w_sat, sal_new, out_new, q_sat;
    logic signed [35:0] mix_acc, w_acc, sal_acc, out_acc, q36;
    logic [16:0]        mag_full;
    logic               keep;
    logic [HR_W:0]      start_row, next_row;
    logic [N_W-1:0]     n_val;
    logic [2*N_W-1:0]   q_prod;
    logic [N_W-1:0]     q_est;
    logic [N_W-1:0]     q_rem;
    logic [N_W-1:0]     q_mag;
    logic signed [N_W-1:0] q_s;
    logic               last_lane;
    logic [AW-1:0]      hist_raddr;

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        case (r_state)
            egc_pkg::S_CLEAR: if (r_clr_addr == AW'(DEPTH - 1)) n_state = egc_pkg::S_IDLE;
            egc_pkg::S_IDLE: begin
                if (i_q_valid) begin
                    n_state = (i_q_item.cmd == egc_pkg::CMD_RETRIEVE) ?
                              egc_pkg::S_RSUM : egc_pkg::S_READ;
                end
            end
            egc_pkg::S_READ:  n_state = egc_pkg::S_MIX;
            egc_pkg::S_MIX:   n_state = egc_pkg::S_WGT;
            egc_pkg::S_WGT:   n_state = egc_pkg::S_UPD;
            egc_pkg::S_UPD:   n_state = egc_pkg::S_OUT;
            egc_pkg::S_RSUM: begin
                if (r_cnt == CNT_W'(CONTEXT_ROWS) && !r_acc_en) n_state = egc_pkg::S_DPREP;
            end
            egc_pkg::S_DPREP: n_state = egc_pkg::S_DIV;
            egc_pkg::S_DIV:   if (r_dstep) n_state = egc_pkg::S_OUT;
            egc_pkg::S_OUT:   if (!r_out_valid || i_out_ready) n_state = egc_pkg::S_IDLE;
            default:          n_state = egc_pkg::S_IDLE;
        endcase
    end

    // Output and strobe logic.
    always_comb begin
        o_q_pop    = 1'b0;
        hist_we    = 1'b0;
        hist_waddr = {r_head, r_item.lane};
        hist_wdata = out_new;
        lane_we    = 1'b0;
        out_load   = 1'b0;
        o_clearing = 1'b0;
        case (r_state)
            egc_pkg::S_CLEAR: begin
                o_clearing = 1'b1;
                hist_we    = 1'b1;
                hist_waddr = r_clr_addr;
                hist_wdata = 16'sd0;
            end
            egc_pkg::S_IDLE: o_q_pop = i_q_valid;
            egc_pkg::S_UPD: begin
                hist_we = 1'b1;
                lane_we = 1'b1;
            end
            egc_pkg::S_OUT: out_load = !r_out_valid || i_out_ready;
            default: ;
        endcase
    end

    // Arithmetic of the process path and the retrieve path.
    always_comb begin
        rec_eff  = r_lane_vld ? r_rec_q : 16'sd0;
        sal_eff  = r_lane_vld ? r_sal_q : egc_pkg::SAL_ONE;
        mix_acc  = (K_MIX_NEW * sx16(r_item.avg) + K_MIX_OLD * sx16(rec_eff) + 36'sd32768) >>> 16;
        w_acc    = (sx16(r_mixed) * sx16(r_sal_eff) + 36'sd2048) >>> 12;
        w_sat    = sat16(w_acc);
        mag_full = w_sat[15] ? (17'd0 - {w_sat[15], w_sat}) : {1'b0, w_sat};
        keep     = mag_full >= {2'b00, i_zero_threshold};
        sal_acc  = (K_SAL_OLD * sx16(r_sal_eff) + K_SAL_NEW * $signed({19'd0, r_mag})
                   + 36'sd32768) >>> 16;
        sal_new  = sat16(sal_acc);
        out_acc  = (sx16(r_w) * $signed({19'd0, 17'h10000 - {1'b0, i_forget_rate}})
                   + 36'sd32768) >>> 16;
        out_new  = sat16(out_acc);
        last_lane = (r_item.lane == LW'(egc_pkg::VECTOR_LEN - 1));

        // Oldest context row and the cyclic row step.
        start_row = ({1'b0, r_head} >= (HR_W + 1)'(OFF)) ?
                    ({1'b0, r_head} - (HR_W + 1)'(OFF)) :
                    ({1'b0, r_head} + (HR_W + 1)'(HISTORY_ROWS - OFF));
        next_row  = ({1'b0, r_row} == (HR_W + 1)'(HISTORY_ROWS - 1)) ?
                    '0 : ({1'b0, r_row} + (HR_W + 1)'(1));
        hist_raddr = {r_row, r_item.lane};

        // Floor division of 2*sum + rows by 2*rows: reciprocal estimate of the
        // magnitude, then one compare and subtract to correct it.
        n_val  = {r_sum[SUM_W-1], r_sum, 1'b0} + N_W'(CONTEXT_ROWS);
        q_prod = (2 * N_W)'(r_a) * (2 * N_W)'(K_RECIP);
        q_est  = q_prod[2*N_W-1:N_W];
        q_rem  = r_a - (r_q0 * K_DIV);
        q_mag  = (q_rem >= K_DIV) ? (r_q0 + N_W'(1)) : r_q0;
        q_s    = r_neg ? $signed(~q_mag) : $signed(q_mag);
        q36    = 36'(q_s);
        q_sat  = sat16(q36);
    end

    // Sequencer state and control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= egc_pkg::S_CLEAR;
            r_clr_addr  <= '0;
            r_head      <= '0;
            r_vld       <= '0;
            r_out_valid <= 1'b0;
            r_acc_en    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == egc_pkg::S_CLEAR) r_clr_addr <= r_clr_addr + AW'(1);
            if (lane_we) begin
                r_vld[r_item.lane] <= 1'b1;
                if (last_lane) begin
                    r_head <= (r_head == HR_W'(HISTORY_ROWS - 1)) ? '0 : r_head + HR_W'(1);
                end
            end
            r_acc_en <= (r_state == egc_pkg::S_RSUM) && (r_cnt != CNT_W'(CONTEXT_ROWS));
            if (out_load) r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            egc_pkg::S_IDLE: begin
                r_item <= i_q_item;
                r_row  <= start_row[HR_W-1:0];
                r_cnt  <= '0;
                r_sum  <= '0;
            end
            egc_pkg::S_READ: r_lane_vld <= r_vld[r_item.lane];
            egc_pkg::S_MIX: begin
                r_mixed   <= sat16(mix_acc);
                r_sal_eff <= sal_eff;
            end
            egc_pkg::S_WGT: begin
                r_w   <= keep ? w_sat : 16'sd0;
                r_mag <= keep ? mag_full : 17'd0;
            end
            egc_pkg::S_UPD: r_res <= out_new;
            egc_pkg::S_RSUM: begin
                if (r_cnt != CNT_W'(CONTEXT_ROWS)) begin
                    r_row <= next_row[HR_W-1:0];
                    r_cnt <= r_cnt + CNT_W'(1);
                end
                if (r_acc_en) r_sum <= r_sum + SUM_W'(r_hist_q);
            end
            egc_pkg::S_DPREP: begin
                r_neg   <= n_val[N_W-1];
                r_a     <= n_val[N_W-1] ? ~n_val : n_val;
                r_dstep <= 1'b0;
            end
            egc_pkg::S_DIV: begin
                if (!r_dstep) begin
                    r_q0    <= q_est;
                    r_dstep <= 1'b1;
                end else begin
                    r_res <= q_sat;
                end
            end
            default: ;
        endcase
        if (out_load) begin
            r_out_value <= r_res;
            r_out_last  <= last_lane;
        end
    end

    // Lane stores: one write and one registered read each.
    always_ff @(posedge i_clk) begin
        if (lane_we) begin
            rec_mem[r_item.lane] <= out_new;
            sal_mem[r_item.lane] <= sal_new;
        end
        r_rec_q <= rec_mem[r_item.lane];
        r_sal_q <= sal_mem[r_item.lane];
    end

    // History memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (hist_we) hist_mem[hist_waddr] <= hist_wdata;
        r_hist_q <= hist_mem[hist_raddr];
    end

    assign o_out_valid      = r_out_valid;
    assign o_result_value   = r_out_value;
    assign o_last_of_vector = r_out_last;

endmodule

[tb/sv/embedding_gist_compressor_core_tb.sv]
// Self-checking testbench for embedding_gist_compressor_core: a directed table
// and random process/retrieve beats, each result checked against a local predictor.
// Depends on egc_pkg and the embedding_gist_compressor_core RTL.
`timescale 1ns / 1ps

module embedding_gist_compressor_core_tb;

    localparam int HIST_ROWS = egc_pkg::HISTORY_ROWS_DEF;
    localparam int CTX_ROWS  = egc_pkg::CONTEXT_ROWS_DEF;
    localparam int NUM_RANDOM = 520;

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_ready;
    logic i_command;
    logic [egc_pkg::LANE_W-1:0] i_lane;
    logic signed [egc_pkg::DATA_W-1:0] i_value_even;
    logic signed [egc_pkg::DATA_W-1:0] i_value_odd;
    logic o_out_valid;
    logic i_out_ready;
    logic signed [egc_pkg::DATA_W-1:0] o_result_value;
    logic o_last_of_vector;
    logic psel;
    logic penable;
    logic pwrite;
    logic [2:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    embedding_gist_compressor_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_command(i_command), .i_lane(i_lane),
        .i_value_even(i_value_even), .i_value_odd(i_value_odd),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_result_value(o_result_value), .o_last_of_vector(o_last_of_vector),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // One expected output beat.
    typedef struct {
        logic signed [egc_pkg::DATA_W-1:0] value;
        logic                              last;
    } t_gist_beat;

    // One row of the directed table; check_value marks rows with a typed-in result.
    typedef struct {
        logic                              cmd;
        logic [egc_pkg::LANE_W-1:0]        lane;
        logic signed [egc_pkg::DATA_W-1:0] even;
        logic signed [egc_pkg::DATA_W-1:0] odd;
        bit                                check_value;
        logic signed [egc_pkg::DATA_W-1:0] value;
    } t_dir_row;

    // Predictor state.
    logic signed [egc_pkg::DATA_W-1:0] gist_history [HIST_ROWS*egc_pkg::VECTOR_LEN];
    logic signed [egc_pkg::DATA_W-1:0] recurrent_mem [egc_pkg::VECTOR_LEN];
    logic signed [egc_pkg::DATA_W-1:0] salience_mem [egc_pkg::VECTOR_LEN];
    int unsigned head_row;
    logic [15:0] forget_cfg;
    logic [14:0] threshold_cfg;

    t_gist_beat expected_beats[$];
    int error_count;
    int send_idle_pct;
    int recv_idle_pct;
    bit recv_hold;

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Runaway guard: clearing pass, slow retrieves and long stalls fit well inside.
    initial begin
        #60ms;
        $display("embedding_gist_compressor_core_tb: errors");
        $finish;
    end

    function automatic longint floor_div(longint a, longint b);
        if (a >= 0) return a / b;
        return -((-a - 1) / b) - 1;
    endfunction

    function automatic longint round_q(longint v, int sh);
        return floor_div(v + (longint'(1) << (sh - 1)), longint'(1) << sh);
    endfunction

    function automatic longint clip16(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    // Expected result of one beat, updating the predictor state.
    function automatic t_gist_beat predict_gist(logic cmd, logic [egc_pkg::LANE_W-1:0] lane,
                                                logic signed [egc_pkg::DATA_W-1:0] even,
                                                logic signed [egc_pkg::DATA_W-1:0] odd);
        t_gist_beat b;
        longint acc, avg, mixed, w, mag, sal, res;
        int unsigned first_row;
        acc = 0;
        if (cmd == egc_pkg::CMD_RETRIEVE) begin
            first_row = (head_row + HIST_ROWS - (CTX_ROWS % HIST_ROWS)) % HIST_ROWS;
            for (int t = 0; t < CTX_ROWS; t++)
                acc += gist_history[((first_row + t) % HIST_ROWS) * egc_pkg::VECTOR_LEN + lane];
            res = clip16(floor_div(2 * acc + CTX_ROWS, 2 * CTX_ROWS));
        end else begin
            avg = floor_div(longint'(even) + longint'(odd), 2);
            mixed = clip16(round_q(45875 * avg + 19661 * longint'(recurrent_mem[lane]), 16));
            w = clip16(round_q(mixed * longint'(salience_mem[lane]), 12));
            mag = (w < 0) ? -w : w;
            if (mag < longint'(threshold_cfg)) begin
                w = 0;
                mag = 0;
            end
            sal = clip16(round_q(58982 * longint'(salience_mem[lane]) + 6554 * mag, 16));
            salience_mem[lane] = (egc_pkg::DATA_W)'(sal);
            res = clip16(round_q(w * (65536 - longint'(forget_cfg)), 16));
            gist_history[head_row * egc_pkg::VECTOR_LEN + lane] = (egc_pkg::DATA_W)'(res);
            recurrent_mem[lane] = (egc_pkg::DATA_W)'(res);
            if (lane == egc_pkg::VECTOR_LEN - 1) head_row = (head_row + 1) % HIST_ROWS;
        end
        b.value = (egc_pkg::DATA_W)'(res);
        b.last = (lane == egc_pkg::VECTOR_LEN - 1);
        return b;
    endfunction

    // Output side: random stalls, plus a long hold-off when requested.
    always @(posedge i_clk) begin
        if (!i_rst_n || recv_hold) begin
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Compare each accepted result with the oldest expectation.
    always @(posedge i_clk) begin
        t_gist_beat exp_b;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_beats.size() == 0) begin
                $error("unexpected result beat value=%0d", o_result_value);
                error_count++;
            end else begin
                exp_b = expected_beats.pop_front();
                if (o_result_value !== exp_b.value) begin
                    $error("result_value expected %0d actual %0d", exp_b.value, o_result_value);
                    error_count++;
                end
                if (o_last_of_vector !== exp_b.last) begin
                    $error("last_of_vector expected %0b actual %0b", exp_b.last,
                           o_last_of_vector);
                    error_count++;
                end
            end
        end
    end

    // APB register write: setup then access cycle.
    task automatic write_reg(logic idx, logic [31:0] data);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == egc_pkg::REG_FORGET_RATE) forget_cfg = data[15:0];
        else threshold_cfg = data[14:0];
    endtask

    // Send one beat with optional idle gap; valid stays high until taken.
    task automatic send_beat(logic cmd, logic [egc_pkg::LANE_W-1:0] lane,
                             logic signed [egc_pkg::DATA_W-1:0] even,
                             logic signed [egc_pkg::DATA_W-1:0] odd, bit check_value,
                             logic signed [egc_pkg::DATA_W-1:0] value);
        t_gist_beat b;
        while ($urandom_range(99) < send_idle_pct) begin
            @(posedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(posedge i_clk);
        i_in_valid <= 1'b1;
        i_command <= cmd;
        i_lane <= lane;
        i_value_even <= even;
        i_value_odd <= odd;
        b = predict_gist(cmd, lane, even, odd);
        if (check_value && b.value !== value) begin
            $error("result_value expected %0d actual %0d", value, b.value);
            error_count++;
        end
        b.value = check_value ? value : b.value;
        expected_beats.push_back(b);
        do @(posedge i_clk); while (!o_in_ready);
        i_in_valid <= 1'b0;
    endtask

    // Let all outstanding beats drain, then allow for a trailing busy back end.
    task automatic drain_block();
        while (expected_beats.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    // Random phase: mostly full in-order vectors with interleaved retrieves.
    task automatic random_phase(int count);
        logic [egc_pkg::LANE_W-1:0] next_lane;
        int sel;
        next_lane = 0;
        for (int n = 0; n < count; n++) begin
            sel = $urandom_range(99);
            if (sel < 12) begin
                send_beat(egc_pkg::CMD_RETRIEVE, (egc_pkg::LANE_W)'($urandom),
                          (egc_pkg::DATA_W)'($urandom), (egc_pkg::DATA_W)'($urandom),
                          1'b0, '0);
            end else if (sel < 20) begin
                send_beat(egc_pkg::CMD_PROCESS, (egc_pkg::LANE_W)'($urandom),
                          (egc_pkg::DATA_W)'($urandom), (egc_pkg::DATA_W)'($urandom),
                          1'b0, '0);
            end else if (sel < 26) begin
                send_beat(egc_pkg::CMD_PROCESS, next_lane, 16'sh7fff,
                          16'sh8000 + (egc_pkg::DATA_W)'($urandom_range(1)), 1'b0, '0);
                next_lane++;
            end else begin
                send_beat(egc_pkg::CMD_PROCESS, next_lane, (egc_pkg::DATA_W)'($urandom),
                          (egc_pkg::DATA_W)'($urandom), 1'b0, '0);
                next_lane++;
            end
        end
    endtask

    t_dir_row dir_table[$];

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_command = egc_pkg::CMD_PROCESS;
        i_lane = '0;
        i_value_even = '0;
        i_value_odd = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        recv_hold = 1'b0;
        error_count = 0;
        send_idle_pct = 36;
        recv_idle_pct = 80;
        for (int i = 0; i < HIST_ROWS * egc_pkg::VECTOR_LEN; i++) gist_history[i] = '0;
        for (int i = 0; i < egc_pkg::VECTOR_LEN; i++) begin
            recurrent_mem[i] = '0;
            salience_mem[i] = egc_pkg::SAL_ONE;
        end
        head_row = 0;
        forget_cfg = egc_pkg::FORGET_RATE_RST;
        threshold_cfg = egc_pkg::ZERO_THRESHOLD_RST;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table: retrieve after reset, extremes, threshold edges.
        dir_table = '{
            '{egc_pkg::CMD_RETRIEVE, 6'd0,  16'sh7fff, 16'sh7fff, 1'b1, 16'sd0},
            '{egc_pkg::CMD_RETRIEVE, 6'd63, 16'sh8000, 16'sh8000, 1'b1, 16'sd0},
            '{egc_pkg::CMD_PROCESS,  6'd0,  16'sd0,    16'sd0,    1'b1, 16'sd0},
            '{egc_pkg::CMD_PROCESS,  6'd1,  16'sh7fff, 16'sh7fff, 1'b0, 16'sd0},
            '{egc_pkg::CMD_PROCESS,  6'd2,  16'sh8000, 16'sh8000, 1'b0, 16'sd0},
            '{egc_pkg::CMD_PROCESS,  6'd3,  16'sh7fff, 16'sh8000, 1'b1, 16'sd0},
            '{egc_pkg::CMD_PROCESS,  6'd4,  16'sd100,  16'sd100,  1'b1, 16'sd0},
            '{egc_pkg::CMD_PROCESS,  6'd5,  -16'sd586, -16'sd586, 1'b0, 16'sd0},
            '{egc_pkg::CMD_PROCESS,  6'd6,  16'sd586,  16'sd585,  1'b0, 16'sd0},
            '{egc_pkg::CMD_PROCESS,  6'd1,  16'sh7fff, 16'sh7fff, 1'b0, 16'sd0},
            '{egc_pkg::CMD_PROCESS,  6'd63, 16'sd4096, -16'sd4096, 1'b0, 16'sd0},
            '{egc_pkg::CMD_RETRIEVE, 6'd1,  16'sd0,    16'sd0,    1'b0, 16'sd0},
            '{egc_pkg::CMD_PROCESS,  6'd62, 16'sh5555, 16'shaaaa, 1'b0, 16'sd0},
            '{egc_pkg::CMD_RETRIEVE, 6'd62, 16'sd0,    16'sd0,    1'b0, 16'sd0},
            '{egc_pkg::CMD_PROCESS,  6'd63, 16'sh7fff, 16'sh7fff, 1'b0, 16'sd0},
            '{egc_pkg::CMD_RETRIEVE, 6'd63, 16'sd0,    16'sd0,    1'b0, 16'sd0}
        };
        foreach (dir_table[k])
            send_beat(dir_table[k].cmd, dir_table[k].lane, dir_table[k].even,
                      dir_table[k].odd, dir_table[k].check_value, dir_table[k].value);
        drain_block();

        // Threshold extreme and no forgetting; exercise random content.
        write_reg(egc_pkg::REG_FORGET_RATE, 32'd0);
        write_reg(egc_pkg::REG_ZERO_THRESHOLD, 32'h7fff);
        random_phase(60);
        drain_block();

        write_reg(egc_pkg::REG_ZERO_THRESHOLD, 32'd0);
        random_phase(140);

        // Long receiver hold-off while the sender keeps offering beats.
        fork
            begin
                recv_hold = 1'b1;
                repeat (400) @(posedge i_clk);
                recv_hold = 1'b0;
            end
            random_phase(20);
        join
        drain_block();

        // Swap idling and use maximal forgetting.
        send_idle_pct = 80;
        recv_idle_pct = 36;
        write_reg(egc_pkg::REG_FORGET_RATE, 32'hffff);
        write_reg(egc_pkg::REG_ZERO_THRESHOLD, 32'd1);
        random_phase(120);
        drain_block();

        // No idling on either side, register values back near reset.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(egc_pkg::REG_FORGET_RATE, 32'd3277);
        write_reg(egc_pkg::REG_ZERO_THRESHOLD, 32'd410);
        random_phase(NUM_RANDOM - 340);
        drain_block();

        if (error_count == 0)
            $display("embedding_gist_compressor_core_tb: clean");
        else
            $display("embedding_gist_compressor_core_tb: errors");
        $finish;
    end

endmodule

[filelist.f]
+incdir+design
design/egc_pkg.sv
design/egc_front.sv
design/egc_back.sv
design/embedding_gist_compressor_core.sv
tb/sv/embedding_gist_compressor_core_tb.sv
